FILE: sv/pip_pkg.sv
// ============================================================================
// pip_pkg: shared definitions for the point-in-polygon ray crossing block
// Holds the store size, derived widths, command codes and controller states.
// ============================================================================
package pip_pkg;

    // Polygon store depth and the widths that follow from it.
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int VCOUNT_W     = $clog2(MAX_VERTICES + 1);

    // Fixed field widths of the stream items and the datapath.
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int COUNT_OUT_W  = 11;
    localparam int IN_DATA_W    = 2 * COORD_W;
    localparam int OUT_DATA_W   = 16;

    // Command codes carried in tuser; the fourth code is ignored.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    // Query controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

FILE: sv/point_in_polygon_ray_crossing.sv
// ============================================================================
// point_in_polygon_ray_crossing: crossing-number point-in-polygon test
// Stores polygon vertices in a synchronous memory and answers point queries.
// ============================================================================
// Usage:
// The slave channel takes one command per transaction. tuser holds the
// command (clear, append vertex, query point) and tdata the point. A clear
// and an append each give no result. An append to a full
// store is dropped. A query walks the polygon edges and returns one result
// transaction on the master channel: the inside flag and the crossing count.
// Walk: a query with n stored vertices issues n + 1 memory reads, one per
// cycle (the closing vertex first, then every vertex in order), followed
// by a three-stage subtract, multiply and accumulate pipeline. An empty
// polygon skips the walk and goes straight to the result. The single read
// port of the vertex memory sets the pace of one edge per cycle. The
// slave channel is not ready while a query is in progress.
// Reset clears the vertex count, the controller and the output register; the
// vertex memory itself is not cleared and needs no clearing pass.
// When the master side stalls, the result waits in the output register and
// clears and appends are still taken; a following query completes its walk
// and then holds until the earlier result has been taken.
// ============================================================================
module point_in_polygon_ray_crossing (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] inside_res, [11:1] crossing_count,
                                        // [15:12] zero
);

    localparam int AW  = pip_pkg::ADDR_W;
    localparam int VW  = pip_pkg::VCOUNT_W;
    localparam int CW  = pip_pkg::COORD_W;
    localparam int DW  = pip_pkg::DIFF_W;
    localparam int PW  = pip_pkg::PROD_W;
    localparam int NW  = pip_pkg::NUM_W;
    localparam int OCW = pip_pkg::COUNT_OUT_W;

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    pip_pkg::state_t state_reg, state_next;
    pip_pkg::cmd_t   in_cmd;

    logic [2*CW-1:0] vert_mem [pip_pkg::MAX_VERTICES];
    logic [2*CW-1:0] rdata_reg;

    logic [VW-1:0]   vcount_reg, vcount_next;
    logic [VW-1:0]   idx_reg, idx_next;
    logic            prime_reg, prime_next;
    logic [VW-1:0]   cross_reg, cross_next;
    logic signed [CW-1:0] qx_reg, qy_reg;

    logic            in_fire, out_fire;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            last_issue;
    logic            pipe_empty;
    logic            out_load;

    // Pipeline valid and edge flags.
    logic            rd_valid_reg, rd_edge_reg;
    logic            d_valid_reg;
    logic            m_valid_reg;

    // Datapath values.
    logic signed [DW-1:0] cur_dx, cur_dy;
    logic signed [DW-1:0] cx_reg, cy_reg, px_reg, py_reg;
    logic                 cy_pos, py_pos, straddle;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic                 straddle_reg, den_pos_reg;
    logic signed [NW-1:0] num;
    logic                 hit;

    logic                 out_valid_reg;
    logic                 out_inside_reg;
    logic [OCW-1:0]       out_count_reg;

    // ------------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------------
    assign in_cmd   = pip_pkg::cmd_t'(s_axis_tuser);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;
    assign mem_we   = in_fire && (in_cmd == pip_pkg::CMD_APPEND)
                      && (vcount_reg < VW'(pip_pkg::MAX_VERTICES));
    assign last_issue = !prime_reg && (idx_reg == (vcount_reg - VW'(1)));
    assign pipe_empty = !rd_valid_reg && !d_valid_reg && !m_valid_reg;

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (in_fire && (in_cmd == pip_pkg::CMD_QUERY))
                begin
                    if (vcount_reg == '0)
                        state_next = pip_pkg::ST_DONE;
                    else
                        state_next = pip_pkg::ST_WALK;
                end
            end
            pip_pkg::ST_WALK:
            begin
                if (last_issue)
                    state_next = pip_pkg::ST_DRAIN;
            end
            pip_pkg::ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = pip_pkg::ST_DONE;
            end
            pip_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = pip_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Controller outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            pip_pkg::ST_WALK:
            begin
                mem_re = 1'b1;
            end
            pip_pkg::ST_DRAIN:
            begin
                mem_re = 1'b0;
            end
            pip_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // The closing vertex is read first so that it serves as the previous end.
    assign mem_raddr = prime_reg ? AW'(vcount_reg - VW'(1)) : idx_reg[AW-1:0];

    // ------------------------------------------------------------------------
    // Vertex count, walk index and crossing accumulator
    // ------------------------------------------------------------------------
    always_comb
    begin
        vcount_next = vcount_reg;
        idx_next    = idx_reg;
        prime_next  = prime_reg;
        cross_next  = cross_reg;
        if (in_fire)
        begin
            case (in_cmd)
                pip_pkg::CMD_CLEAR:
                begin
                    vcount_next = '0;
                end
                pip_pkg::CMD_APPEND:
                begin
                    if (mem_we)
                        vcount_next = vcount_reg + VW'(1);
                end
                pip_pkg::CMD_QUERY:
                begin
                    idx_next   = '0;
                    prime_next = 1'b1;
                    cross_next = '0;
                end
                default:
                begin
                    vcount_next = vcount_reg;
                end
            endcase
        end
        if (mem_re)
        begin
            if (prime_reg)
                prime_next = 1'b0;
            else
                idx_next = idx_reg + VW'(1);
        end
        if (m_valid_reg && hit)
            cross_next = cross_reg + VW'(1);
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pip_pkg::ST_IDLE;
            vcount_reg   <= '0;
            idx_reg      <= '0;
            prime_reg    <= 1'b0;
            cross_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_edge_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            idx_reg      <= idx_next;
            prime_reg    <= prime_next;
            cross_reg    <= cross_next;
            rd_valid_reg <= mem_re;
            rd_edge_reg  <= mem_re && !prime_reg;
            // Only reads that close an edge move on past the diff stage.
            d_valid_reg  <= rd_valid_reg && rd_edge_reg;
            m_valid_reg  <= d_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Vertex memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vert_mem[vcount_reg[AW-1:0]] <= {s_axis_tdata[2*CW-1:CW],
                                             s_axis_tdata[CW-1:0]};
        if (mem_re)
            rdata_reg <= vert_mem[mem_raddr];
    end

    // ------------------------------------------------------------------------
    // Stage 1: move the origin to the query point
    // ------------------------------------------------------------------------
    assign cur_dx = DW'($signed(rdata_reg[CW-1:0])) - DW'(qx_reg);
    assign cur_dy = DW'($signed(rdata_reg[2*CW-1:CW])) - DW'(qy_reg);

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_cmd == pip_pkg::CMD_QUERY))
        begin
            qx_reg <= $signed(s_axis_tdata[CW-1:0]);
            qy_reg <= $signed(s_axis_tdata[2*CW-1:CW]);
        end
        if (rd_valid_reg)
        begin
            cx_reg <= cur_dx;
            cy_reg <= cur_dy;
            px_reg <= cx_reg;
            py_reg <= cy_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: straddle test and cross products
    // ------------------------------------------------------------------------
    assign cy_pos   = !cy_reg[DW-1] && (cy_reg != '0);
    assign py_pos   = !py_reg[DW-1] && (py_reg != '0);
    assign straddle = cy_pos != py_pos;

    always_ff @(posedge clk)
    begin
        if (d_valid_reg)
        begin
            prod_a_reg   <= cx_reg * py_reg;
            prod_b_reg   <= px_reg * cy_reg;
            straddle_reg <= straddle;
            // With a straddling edge, py - cy is positive exactly when py is.
            den_pos_reg  <= py_pos;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: exact sign test of the intersection
    // ------------------------------------------------------------------------
    assign num = NW'(prod_a_reg) - NW'(prod_b_reg);
    assign hit = straddle_reg && (num != '0) && (num[NW-1] != den_pos_reg);

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_inside_reg <= cross_reg[0];
            out_count_reg  <= OCW'(cross_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(pip_pkg::OUT_DATA_W - OCW - 1)'(0),
                            out_count_reg, out_inside_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VW'(pip_pkg::MAX_VERTICES))
        else $error("Vertex count exceeds the store depth.");

    a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pip_pkg::ST_IDLE) |-> (cross_reg <= vcount_reg))
        else $error("Crossing count exceeds the number of edges.");

    a_reads_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == pip_pkg::ST_WALK ||
                          state_reg == pip_pkg::ST_DRAIN))
        else $error("Memory read data arrived outside a query walk.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pip_pkg::ST_DONE && out_valid_reg && !m_axis_tready)
        |=> (state_reg == pip_pkg::ST_DONE))
        else $error("Query result would overwrite a pending result.");

endmodule
